FILE: hdl/lsbse_pkg.sv
// ----------------------------------------------------------------------------
// lsbse_pkg: shared types and constants of the LSB steganography embedder
// Command codes, the item layouts of both channels, the internal queue entry
// and the front-end status word.
// ----------------------------------------------------------------------------
`default_nettype none

package lsbse_pkg;

   localparam int MESSAGE_DEPTH_DEFAULT = 256;
   localparam logic [15:0] HEADER_LENGTH_RESET = 16'd54;
   localparam logic [1:0] CHANNEL_ALPHA = 2'd3;
   localparam logic [2:0] BIT_LAST = 3'd7;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_BYTE    = 2'd1,
      CMD_RESTART = 2'd2,
      CMD_UNUSED  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_in;
   } req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       carried_bit;
      logic       embedding_done;
   } rsp_type;

   typedef struct packed {
      cmd_type    op;
      logic [7:0] data;
   } entry_type;

   typedef struct packed {
      logic       full;
      logic [1:0] count;
   } fe_status_type;

endpackage

`default_nettype wire

FILE: hdl/lsbse_front.sv
// ----------------------------------------------------------------------------
// lsbse_front: input acceptance, command classification and two-word queue
// Unused command codes are dropped here; every other word is queued in order
// for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbse_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire lsbse_pkg::req_type       req_payload,
   output logic                          q_valid,
   output lsbse_pkg::entry_type          q_entry,
   input  wire logic                     q_pop,
   output lsbse_pkg::fe_status_type      status
);
   import lsbse_pkg::*;

   entry_type  entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_stall = (count_ff == 2'd2);
   // drop the unused command code at the door
   assign push = req_valid && !req_stall && (cmd_type'(req_payload.command) != CMD_UNUSED);
   assign q_valid = (count_ff != 2'd0);
   assign q_entry = entry_ff[rd_ptr_ff];
   assign status = '{full: req_stall, count: count_ff};

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{op: cmd_type'(req_payload.command), data: req_payload.data_in};
      end
   end

endmodule

`default_nettype wire

FILE: hdl/lsbse_back.sv
// ----------------------------------------------------------------------------
// lsbse_back: message store, embedding state and result register
// One queued word per cycle, bytes only while rsp_ is free: loads fill the
// store, bytes get their LSB replaced, restart clears counters and message.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbse_back #(
   parameter int MESSAGE_DEPTH = lsbse_pkg::MESSAGE_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [15:0]           header_length,
   input  wire logic                  q_valid,
   input  wire lsbse_pkg::entry_type  q_entry,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output lsbse_pkg::rsp_type         rsp_payload
);
   import lsbse_pkg::*;

   localparam int CW = $clog2(MESSAGE_DEPTH + 1);
   localparam int AW = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(MESSAGE_DEPTH);

   typedef enum logic [2:0] {
      PH_HEADER = 3'b001,
      PH_EMBED  = 3'b010,
      PH_DONE   = 3'b100
   } phase_type;

   logic [7:0]    mem [MESSAGE_DEPTH];
   logic [7:0]    rd_data_ff;
   logic [7:0]    byp_data_ff;
   logic          byp_ff;

   phase_type     phase_ff, phase_in;
   logic [CW-1:0] count_ff, count_in;
   logic          closed_ff, closed_in;
   logic [CW-1:0] read_ff, read_in;
   logic [2:0]    bit_ff, bit_in;
   logic [15:0]   hdr_ff, hdr_in;
   logic [1:0]    chan_ff, chan_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          out_free;
   logic          is_load, is_byte, is_restart;
   logic          mem_we;
   logic          in_header;
   logic [7:0]    cur_char;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign q_pop      = q_valid && ((q_entry.op != CMD_BYTE) || out_free);
   assign is_load    = q_pop && (q_entry.op == CMD_LOAD);
   assign is_byte    = q_pop && (q_entry.op == CMD_BYTE);
   assign is_restart = q_pop && (q_entry.op == CMD_RESTART);
   assign in_header  = (hdr_ff < header_length);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // current character, terminator past the stored message
   always_comb begin
      if (read_ff < count_ff) begin
         cur_char = byp_ff ? byp_data_ff : rd_data_ff;
      end else begin
         cur_char = 8'd0;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      closed_in    = closed_ff;
      read_in      = read_ff;
      bit_in       = bit_ff;
      hdr_in       = hdr_ff;
      chan_in      = chan_ff;
      mem_we       = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (is_restart) begin
         phase_in  = PH_HEADER;
         count_in  = '0;
         closed_in = 1'b0;
         read_in   = '0;
         bit_in    = 3'd0;
         hdr_in    = 16'd0;
         chan_in   = 2'd0;
      end else if (is_load) begin
         // loads count only before the first file byte
         if ((phase_ff == PH_HEADER) && (hdr_ff == 16'd0) && !closed_ff) begin
            if (q_entry.data == 8'd0) begin
               closed_in = 1'b1;
            end else if (count_ff < DEPTH_C) begin
               mem_we   = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
      end else if (is_byte) begin
         rsp_in.data_out    = q_entry.data;
         rsp_in.carried_bit = 1'b0;
         if ((phase_ff == PH_HEADER) && in_header) begin
            hdr_in = hdr_ff + 16'd1;
         end else if ((phase_ff != PH_DONE) && !in_header) begin
            phase_in = PH_EMBED;
            chan_in  = chan_ff + 2'd1;
            if (chan_ff != CHANNEL_ALPHA) begin
               rsp_in.data_out    = {q_entry.data[7:1], cur_char[bit_ff]};
               rsp_in.carried_bit = 1'b1;
               bit_in             = bit_ff + 3'd1;
               if (bit_ff == BIT_LAST) begin
                  if (read_ff >= count_ff) begin
                     phase_in = PH_DONE;
                  end else begin
                     read_in = read_ff + CW'(1);
                  end
               end
            end
         end else if (phase_ff == PH_HEADER) begin
            phase_in = PH_EMBED;
         end
         rsp_in.embedding_done = (phase_in == PH_DONE);
         rsp_valid_in          = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         count_ff     <= '0;
         closed_ff    <= 1'b0;
         read_ff      <= '0;
         bit_ff       <= 3'd0;
         hdr_ff       <= 16'd0;
         chan_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         closed_ff    <= closed_in;
         read_ff      <= read_in;
         bit_ff       <= bit_in;
         hdr_ff       <= hdr_in;
         chan_ff      <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // store: one write, one registered read that tracks the next read index
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[AW-1:0]] <= q_entry.data;
      end
      rd_data_ff  <= mem[read_in[AW-1:0]];
      byp_ff      <= mem_we && (count_ff[AW-1:0] == read_in[AW-1:0]);
      byp_data_ff <= q_entry.data;
   end

endmodule

`default_nettype wire

FILE: hdl/lsb_steganography_embedder.sv
// ----------------------------------------------------------------------------
// lsb_steganography_embedder: hide a text message in the LSBs of pixel bytes
// Loads message characters into a store, then streams a bitmap through,
// replacing the LSB of each non-alpha pixel byte with the next message bit.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               word
//   req_      in         req_valid / req_stall   command, data_in
//   rsp_      out        rsp_valid / rsp_stall   data_out, carried_bit, done
//   csr_      in         csr_write_enable        header_length (16 bits)
//
// One word per cycle sustained while rsp_stall is low: an accepted file byte
// passes through the queue and then the result register before rsp_ sees it.
// Reset is synchronous: counters, phase and queue clear, header_length
// returns to 54; the store itself is never cleared.
// req_stall rises only when rsp_stall has held file bytes back and filled the
// two-word queue; loads and restarts drain even while rsp_ stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module lsb_steganography_embedder #(
   parameter int MESSAGE_DEPTH = lsbse_pkg::MESSAGE_DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire lsbse_pkg::req_type  req_payload,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output lsbse_pkg::rsp_type       rsp_payload,
   input  wire logic                csr_write_enable,
   input  wire logic [15:0]         csr_write_data
);
   import lsbse_pkg::*;

   logic [15:0]   header_length_ff;
   logic [15:0]   header_length_in;
   logic          q_valid;
   logic          q_pop;
   entry_type     q_entry;
   fe_status_type fe_status;

   // header length register: hold unless written
   assign header_length_in = csr_write_enable ? csr_write_data : header_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_length_ff <= HEADER_LENGTH_RESET;
      end else begin
         header_length_ff <= header_length_in;
      end
   end

   // front end: accept, drop unused codes, queue
   lsbse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop),
      .status      (fe_status)
   );

   // back end: store, embedding counters, result register
   lsbse_back #(
      .MESSAGE_DEPTH (MESSAGE_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .header_length (header_length_ff),
      .q_valid       (q_valid),
      .q_entry       (q_entry),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload)
   );

   // after reset nothing is pending and the input side is open
   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result pending or input stalled right after reset");

   // an accepted word is still queued or being executed in the next cycle
   a_accept_queued: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_payload.command != CMD_UNUSED)
      |=> (fe_status.count != 2'd0) || $past(q_pop))
      else $error("accepted word lost from the queue");

   // the queue never reports full with fewer than two words held
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      fe_status.full |-> (fe_status.count == 2'd2) && !$past(q_pop && !fe_status.full))
      else $error("queue full flag disagrees with its count");

endmodule

`default_nettype wire
